// ===== design/tmst_pkg.sv =====
// ----------------------------------------------------------------------------
// tmst_pkg
// shared types, constants and helpers of the token mutex site transitions core
// ----------------------------------------------------------------------------
package tmst_pkg;

    localparam int SITE_W    = 4;
    localparam int FUNC_W    = 2;
    localparam int CNT_W     = 2;
    localparam int SITES_DEF = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = 2'd3;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REQUEST = 2'd0,
        FUNC_TRANSIT = 2'd1,
        FUNC_OK      = 2'd2,
        FUNC_ACK     = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_X,
        ST_EXEC,
        ST_WR_X,
        ST_DONE
    } state_t;

    // update of father pointers and ack flags, applied together
    typedef struct packed {
        logic              father_we;
        logic [SITE_W-1:0] father_site;
        logic [SITE_W-1:0] father_val;
        logic              ack_set;
        logic [SITE_W-1:0] ack_set_site;
        logic              ack_clr;
        logic [SITE_W-1:0] ack_clr_site;
    } site_upd_t;

    function automatic logic site_in_range(logic [SITE_W-1:0] s, int unsigned n);
        return (s != '0) && ({1'b0, s} <= (SITE_W+1)'(n));
    endfunction

endpackage

// ===== design/tmst_ram.sv =====
// ----------------------------------------------------------------------------
// tmst_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module tmst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/tmst_site_regs.sv =====
// ----------------------------------------------------------------------------
// tmst_site_regs
// father pointers and ack flags of all sites, one read port, one update a cycle
// ----------------------------------------------------------------------------
module tmst_site_regs #(
    parameter int SITES = tmst_pkg::SITES_DEF,
    parameter int IW    = (SITES > 1) ? $clog2(SITES) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [tmst_pkg::SITE_W-1:0] rd_site,
    output logic [tmst_pkg::SITE_W-1:0] rd_father,
    output logic                        rd_ack,
    input  tmst_pkg::site_upd_t         upd
);
    import tmst_pkg::*;

    logic [SITE_W-1:0] father_reg [SITES];
    logic              ack_reg    [SITES];

    logic [SITE_W-1:0] rd_m1, fw_m1, as_m1, ac_m1;
    logic [IW-1:0]     rd_idx, fw_idx, as_idx, ac_idx;
    logic              rd_ok;

    assign rd_m1  = rd_site - SITE_W'(1);
    assign fw_m1  = upd.father_site - SITE_W'(1);
    assign as_m1  = upd.ack_set_site - SITE_W'(1);
    assign ac_m1  = upd.ack_clr_site - SITE_W'(1);
    assign rd_idx = rd_m1[IW-1:0];
    assign fw_idx = fw_m1[IW-1:0];
    assign as_idx = as_m1[IW-1:0];
    assign ac_idx = ac_m1[IW-1:0];
    assign rd_ok  = site_in_range(rd_site, SITES);

    assign rd_father = rd_ok ? father_reg[rd_idx] : '0;
    assign rd_ack    = rd_ok ? ack_reg[rd_idx] : 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SITES; i++)
            begin
                father_reg[i] <= SITE_W'(1);
                ack_reg[i]    <= 1'b0;
            end
        end
        else
        begin
            if (upd.father_we)
            begin
                father_reg[fw_idx] <= upd.father_val;
            end
            if (upd.ack_set)
            begin
                ack_reg[as_idx] <= 1'b1;
            end
            if (upd.ack_clr)
            begin
                ack_reg[ac_idx] <= 1'b0;
            end
        end
    end

endmodule

// ===== design/token_mutex_site_transitions_core.sv =====
// ----------------------------------------------------------------------------
// token_mutex_site_transitions_core
// guarded request, transit, ok and ack actions over all sites of a token tree
// ----------------------------------------------------------------------------
// sequence: an accepted item passes ST_RD_X, ST_EXEC, ST_WR_X (only for a transit
//   that fires) and ST_DONE, where it waits until the output register is free;
//   a new item is taken only back in ST_IDLE. The steps come from the registered
//   read port of the bag ram (row x, then row of father) and its single write
//   port (a transit writes two rows)
// reset: fathers point to site 1, acks cleared, every bag row flagged empty
//   through per-row valid flags, so no clearing pass is needed
module token_mutex_site_transitions_core #(
    parameter int SITES = tmst_pkg::SITES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tmst_pkg::FUNC_W-1:0] func,
    input  logic [tmst_pkg::SITE_W-1:0] site_x,
    input  logic [tmst_pkg::SITE_W-1:0] site_y,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        fired,
    output logic [tmst_pkg::SITE_W-1:0] father_after,
    output logic                        ack_after
);
    import tmst_pkg::*;

    localparam int IW    = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int ROW_W = SITES * CNT_W;

    // control state
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   row_valid_reg [SITES];
    logic   rd_valid_reg;

    // item held while it is worked on
    func_t             func_reg;
    logic [SITE_W-1:0] x_reg, y_reg, f_reg;
    logic              x_ok_reg, y_ok_reg;
    logic [ROW_W-1:0]  row_x_reg, row_x_next;

    // result waiting for the output register
    logic              res_fired_reg, res_fired_next;
    logic [SITE_W-1:0] res_father_reg, res_father_next;
    logic              res_ack_reg, res_ack_next;

    // output register
    logic              fired_reg;
    logic [SITE_W-1:0] father_after_reg;
    logic              ack_after_reg;

    // bag ram: one row per owner site, one saturating count per member
    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata;

    // site registers
    logic [SITE_W-1:0] sr_rd_site, sr_father;
    logic              sr_ack;
    site_upd_t         upd;

    logic              accept;
    logic              out_load;
    logic [SITE_W-1:0] x_m1, y_m1, f_m1;
    logic [IW-1:0]     xi, yi, fi;
    logic [ROW_W-1:0]  row_f, row_f_new, row_x_new;
    logic [CNT_W-1:0]  cnt_fx, cnt_fy, cnt_xy;
    logic              is_root, bag_x_empty;
    logic              g_request, g_transit, g_ok, g_ack;

    tmst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SITES),
        .AW    (IW)
    ) u_bag_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tmst_site_regs #(
        .SITES (SITES),
        .IW    (IW)
    ) u_site_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_site   (sr_rd_site),
        .rd_father (sr_father),
        .rd_ack    (sr_ack),
        .upd       (upd)
    );

    assign accept   = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // site indexes, counted from zero
    assign x_m1 = x_reg - SITE_W'(1);
    assign y_m1 = y_reg - SITE_W'(1);
    assign f_m1 = f_reg - SITE_W'(1);
    assign xi   = x_m1[IW-1:0];
    assign yi   = y_m1[IW-1:0];
    assign fi   = f_m1[IW-1:0];

    // father of x is looked up at accept, the ack of x while executing
    assign sr_rd_site = (state_reg == ST_IDLE) ? site_x : x_reg;

    // row of the father arrives in the exec cycle; never written rows are empty
    assign row_f  = rd_valid_reg ? ram_rdata : '0;
    assign cnt_fx = row_f[xi*CNT_W +: CNT_W];
    assign cnt_fy = row_f[yi*CNT_W +: CNT_W];
    assign cnt_xy = row_x_reg[yi*CNT_W +: CNT_W];

    assign is_root     = (f_reg == x_reg);
    assign bag_x_empty = (row_x_reg == '0);

    // guards
    assign g_request = x_ok_reg && (func_reg == FUNC_REQUEST) && !is_root && bag_x_empty;
    assign g_transit = x_ok_reg && y_ok_reg && (func_reg == FUNC_TRANSIT) && !is_root
                       && (cnt_xy != '0);
    assign g_ok      = x_ok_reg && y_ok_reg && (func_reg == FUNC_OK) && is_root
                       && (cnt_xy != '0);
    assign g_ack     = x_ok_reg && (func_reg == FUNC_ACK) && sr_ack;

    // saturating add into the father's bag, decrement in x's bag
    always_comb
    begin
        row_f_new = row_f;
        row_x_new = row_x_reg;
        if (func_reg == FUNC_REQUEST)
        begin
            if (cnt_fx != CNT_MAX)
            begin
                row_f_new[xi*CNT_W +: CNT_W] = cnt_fx + CNT_W'(1);
            end
        end
        else
        begin
            if (cnt_fy != CNT_MAX)
            begin
                row_f_new[yi*CNT_W +: CNT_W] = cnt_fy + CNT_W'(1);
            end
        end
        row_x_new[yi*CNT_W +: CNT_W] = cnt_xy - CNT_W'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RD_X;
                end
            end
            ST_RD_X:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = g_transit ? ST_WR_X : ST_DONE;
            end
            ST_WR_X:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer: ram ports, site updates, result
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        ram_raddr       = '0;
        ram_we          = 1'b0;
        ram_waddr       = fi;
        ram_wdata       = row_f_new;
        upd             = '0;
        row_x_next      = row_x_reg;
        res_fired_next  = res_fired_reg;
        res_father_next = res_father_reg;
        res_ack_next    = res_ack_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                // row of x; an out of range site reads row 0, unused
                if (site_in_range(site_x, SITES))
                begin
                    ram_raddr = IW'(site_x - SITE_W'(1));
                end
            end
            ST_RD_X:
            begin
                row_x_next = rd_valid_reg ? ram_rdata : '0;
                ram_raddr  = fi;
            end
            ST_EXEC:
            begin
                if (g_request || g_transit)
                begin
                    ram_we = 1'b1;
                end
                else if (g_ok)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = xi;
                    ram_wdata = row_x_new;
                end
                row_x_next = row_x_new;

                upd.father_we    = g_request || g_transit || g_ok;
                upd.father_site  = x_reg;
                upd.father_val   = g_request ? x_reg : y_reg;
                upd.ack_set      = g_ok;
                upd.ack_set_site = y_reg;
                upd.ack_clr      = g_ack;
                upd.ack_clr_site = x_reg;

                res_fired_next = g_request || g_transit || g_ok || g_ack;
                if (!x_ok_reg)
                begin
                    res_father_next = '0;
                    res_ack_next    = 1'b0;
                end
                else
                begin
                    res_father_next = upd.father_we ? upd.father_val : f_reg;
                    if (g_ack)
                    begin
                        res_ack_next = 1'b0;
                    end
                    else if (g_ok && (y_reg == x_reg))
                    begin
                        res_ack_next = 1'b1;
                    end
                    else
                    begin
                        res_ack_next = sr_ack;
                    end
                end
            end
            ST_WR_X:
            begin
                // second row of a transit
                ram_we    = 1'b1;
                ram_waddr = xi;
                ram_wdata = row_x_reg;
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            for (int i = 0; i < SITES; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rd_valid_reg  <= row_valid_reg[ram_raddr];
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg <= func_t'(func);
            x_reg    <= site_x;
            y_reg    <= site_y;
            f_reg    <= sr_father;
            x_ok_reg <= site_in_range(site_x, SITES);
            y_ok_reg <= site_in_range(site_y, SITES);
        end
        row_x_reg      <= row_x_next;
        res_fired_reg  <= res_fired_next;
        res_father_reg <= res_father_next;
        res_ack_reg    <= res_ack_next;
        if (out_load)
        begin
            fired_reg        <= res_fired_reg;
            father_after_reg <= res_father_reg;
            ack_after_reg    <= res_ack_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign fired        = fired_reg;
    assign father_after = father_after_reg;
    assign ack_after    = ack_after_reg;

endmodule
